FILE: hdl/dvr_pkg.sv
package dvr_pkg;

  // Field widths of the item and result channels
  localparam int ID_W       = 4;
  localparam int COST_W     = 20;
  localparam int ACT_W      = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 48;

  // Default table size
  localparam int NODES_DEF  = 16;

  // All-ones cost stands for an unreachable destination
  localparam logic [COST_W-1:0] COST_INF = '1;

  // Item actions
  localparam logic [ACT_W-1:0] ACT_LINK  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ADV   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;
  localparam logic [ACT_W-1:0] ACT_ROUND = 2'd3;

  // Address choice for the cost table read port
  typedef enum logic [1:0] {
    TS_LINK,   // diagonal entry of the neighbour: its link cost
    TS_BEST,   // entry in the column of the current best hop
    TS_ENT     // entry of the destination via the neighbour
  } tbl_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     cap_item;
    logic     hop_rd;
    logic     tbl_rd;
    tbl_sel_t tbl_sel;
    logic     out_phase;
    logic     cap_link;
    logic     cap_best;
    logic     upd;
    logic     clr;
    logic     load_out;
  } dvr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic out_full;
  } dvr_sts_t;

endpackage

FILE: hdl/dvr_ctrl.sv
module dvr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              out_tready,
  input  dvr_pkg::dvr_sts_t sts,
  output dvr_pkg::dvr_cmd_t cmd
);
  import dvr_pkg::*;

  localparam logic [3:0] ST_CLR     = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_RD_HOP  = 4'd2;
  localparam logic [3:0] ST_RD_BEST = 4'd3;
  localparam logic [3:0] ST_RD_ENT  = 4'd4;
  localparam logic [3:0] ST_UPD     = 4'd5;
  localparam logic [3:0] ST_O_HOP   = 4'd6;
  localparam logic [3:0] ST_O_BEST  = 4'd7;
  localparam logic [3:0] ST_O_ENT   = 4'd8;
  localparam logic [3:0] ST_DONE    = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  // Sequence the clear sweep and each item's reads, update, read-back
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.cap_item = 1'b1;
          state_nxt    = ST_RD_HOP;
        end
      end
      ST_RD_HOP: begin
        cmd.hop_rd  = 1'b1;
        cmd.tbl_rd  = 1'b1;
        cmd.tbl_sel = TS_LINK;
        state_nxt   = ST_RD_BEST;
      end
      ST_RD_BEST: begin
        cmd.cap_link = 1'b1;
        cmd.tbl_rd   = 1'b1;
        cmd.tbl_sel  = TS_BEST;
        state_nxt    = ST_RD_ENT;
      end
      ST_RD_ENT: begin
        cmd.cap_best = 1'b1;
        cmd.tbl_rd   = 1'b1;
        cmd.tbl_sel  = TS_ENT;
        state_nxt    = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = ST_O_HOP;
      end
      ST_O_HOP: begin
        cmd.out_phase = 1'b1;
        cmd.hop_rd    = 1'b1;
        state_nxt     = ST_O_BEST;
      end
      ST_O_BEST: begin
        cmd.out_phase = 1'b1;
        cmd.tbl_rd    = 1'b1;
        cmd.tbl_sel   = TS_BEST;
        state_nxt     = ST_O_ENT;
      end
      ST_O_ENT: begin
        cmd.out_phase = 1'b1;
        cmd.cap_best  = 1'b1;
        cmd.tbl_rd    = 1'b1;
        cmd.tbl_sel   = TS_ENT;
        state_nxt     = ST_DONE;
      end
      ST_DONE: begin
        cmd.out_phase = 1'b1;
        // hold until the output register is free or being drained
        if (!sts.out_full || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hdl/dvr_dpath.sv
module dvr_dpath #(
  parameter int NODES = dvr_pkg::NODES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [dvr_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [dvr_pkg::ACT_W-1:0]        in_tuser,
  input  logic                             cfg_wr_en,
  input  logic [dvr_pkg::ID_W-1:0]         cfg_wr_data,
  input  dvr_pkg::dvr_cmd_t                cmd,
  output dvr_pkg::dvr_sts_t                sts,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [dvr_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import dvr_pkg::*;

  localparam int IDX_W     = $clog2(NODES);
  localparam int TBL_AW    = 2 * IDX_W;
  localparam int TBL_DEPTH = 1 << TBL_AW;
  localparam int HOP_DEPTH = 1 << IDX_W;

  // Cost table (row = destination, column = via) and best hop per row
  logic [COST_W-1:0] tbl_mem [TBL_DEPTH];
  logic [IDX_W-1:0]  hop_mem [HOP_DEPTH];

  logic [ACT_W-1:0]      act_r;
  logic [ID_W-1:0]       nb_r;
  logic [ID_W-1:0]       dst_r;
  logic [COST_W-1:0]     cost_r;
  logic [COST_W-1:0]     link_r;
  logic [COST_W-1:0]     best_r;
  logic [ID_W-1:0]       own_r;
  logic                  stable_r;
  logic                  stable_nxt;
  logic                  improved_r;
  logic [TBL_AW-1:0]     clr_cnt_r;
  logic [COST_W-1:0]     tbl_rdata_r;
  logic [IDX_W-1:0]      hop_rdata_r;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [IDX_W-1:0]  nb_idx;
  logic [IDX_W-1:0]  dst_idx;
  logic [IDX_W-1:0]  row_idx;
  logic              nb_ok;
  logic              dst_ok;
  logic [TBL_AW-1:0] tbl_rd_addr;
  logic [COST_W:0]   sum;
  logic              adv_ok;
  logic              tbl_we;
  logic [TBL_AW-1:0] tbl_wa;
  logic [COST_W-1:0] tbl_wd;
  logic              hop_we;
  logic [IDX_W-1:0]  hop_wa;
  logic [IDX_W-1:0]  hop_wd;
  logic              improve;
  logic [COST_W-1:0] best_out;
  logic [ID_W-1:0]   hop_out;
  logic [COST_W-1:0] ent_out;

  // Index decode and range checks
  assign nb_idx  = IDX_W'(nb_r);
  assign dst_idx = IDX_W'(dst_r);
  assign nb_ok   = int'(nb_r) < NODES;
  assign dst_ok  = int'(dst_r) < NODES;
  // a link load works on the neighbour's row; its read-back and all else on the destination's
  assign row_idx = (cmd.out_phase || act_r != ACT_LINK) ? dst_idx : nb_idx;

  always_comb begin
    unique case (cmd.tbl_sel)
      TS_LINK: tbl_rd_addr = {nb_idx, nb_idx};
      TS_BEST: tbl_rd_addr = {row_idx, hop_rdata_r};
      TS_ENT:  tbl_rd_addr = {dst_idx, nb_idx};
      default: tbl_rd_addr = {dst_idx, nb_idx};
    endcase
  end

  // Advertised path cost and its validity
  assign sum    = {1'b0, cost_r} + {1'b0, link_r};
  assign adv_ok = nb_ok && dst_ok && (dst_r != own_r) && (cost_r != COST_INF) &&
                  (link_r != COST_INF) && (sum < {1'b0, COST_INF});

  // Table and hop writes: clearing pass or one item's update
  always_comb begin
    tbl_we     = 1'b0;
    tbl_wa     = {row_idx, nb_idx};
    tbl_wd     = cost_r;
    hop_we     = 1'b0;
    hop_wa     = row_idx;
    hop_wd     = nb_idx;
    improve    = 1'b0;
    stable_nxt = stable_r;
    if (cmd.clr) begin
      tbl_we = 1'b1;
      tbl_wa = clr_cnt_r;
      tbl_wd = COST_INF;
      hop_we = 1'b1;
      hop_wa = clr_cnt_r[IDX_W-1:0];
      hop_wd = '0;
    end else if (cmd.upd) begin
      unique case (act_r)
        ACT_LINK: begin
          if (nb_ok) begin
            tbl_we = 1'b1;
            if (cost_r < best_r) begin
              hop_we  = 1'b1;
              improve = 1'b1;
            end
          end
        end
        ACT_ADV: begin
          if (adv_ok) begin
            if (sum[COST_W-1:0] < best_r) begin
              hop_we     = 1'b1;
              improve    = 1'b1;
              stable_nxt = 1'b0;
            end
            // the entry read last holds the current cost via this neighbour
            if (sum[COST_W-1:0] < tbl_rdata_r) begin
              tbl_we = 1'b1;
              tbl_wd = sum[COST_W-1:0];
            end
          end
        end
        ACT_ROUND: begin
          stable_nxt = 1'b1;
        end
        ACT_QUERY: begin
        end
      endcase
    end
  end

  // Memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    if (cmd.tbl_rd) begin
      tbl_rdata_r <= tbl_mem[tbl_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (hop_we) begin
      hop_mem[hop_wa] <= hop_wd;
    end
    if (cmd.hop_rd) begin
      hop_rdata_r <= hop_mem[row_idx];
    end
  end

  // Item fields and intermediate costs
  always_ff @(posedge clk) begin
    if (cmd.cap_item) begin
      act_r  <= in_tuser;
      nb_r   <= in_tdata[ID_W-1:0];
      dst_r  <= in_tdata[2*ID_W-1:ID_W];
      cost_r <= in_tdata[2*ID_W+COST_W-1:2*ID_W];
    end
    if (cmd.cap_link) begin
      link_r <= tbl_rdata_r;
    end
    if (cmd.cap_best) begin
      best_r <= tbl_rdata_r;
    end
    if (cmd.upd) begin
      improved_r <= improve;
    end
  end

  // Control registers: own id, stable flag, clearing counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r     <= '0;
      stable_r  <= 1'b0;
      clr_cnt_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        own_r <= cfg_wr_data;
      end
      stable_r <= stable_nxt;
      if (cmd.clr) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  // Result fields, masked for out-of-range nodes
  assign best_out = dst_ok ? best_r : COST_INF;
  assign hop_out  = dst_ok ? ID_W'(hop_rdata_r) : '0;
  assign ent_out  = (dst_ok && nb_ok) ? tbl_rdata_r : COST_INF;

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= {2'b00, stable_r, improved_r, ent_out, hop_out, best_out};
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign sts.out_full = out_valid_r;
  assign sts.clr_last = (clr_cnt_r == {TBL_AW{1'b1}});

endmodule

FILE: hdl/distance_vector_route_update_unit.sv
// Distance-vector route table of one router.
// Input channel (in_*): in_tuser carries the action (link cost load,
// advertised entry, query, start of round); in_tdata carries neighbour,
// destination and cost. Result channel (out_*): one result per item with
// best cost and next hop to the destination, the table cost via the
// neighbour, the improved flag and the round-stable flag.
// cfg_wr_en/cfg_wr_data set this router's own node number.
// Items are handled one at a time: each runs through RD_HOP, RD_BEST,
// RD_ENT, UPD, O_HOP, O_BEST, O_ENT and DONE before the next is taken.
// This comes from the single read port of the cost table, which is visited
// in turn for the link cost, the best-hop entry and the via entry before
// the update, and for the best-hop and via entries again after it.
// After reset the cost table is swept to infinity and best hops to zero,
// one entry per cycle over all 2^(2*clog2(NODES)) entries (256 for 16
// nodes), with in_tready low. Configuration writes are taken throughout.
// The output register frees the core: the next item is taken while a
// result waits; with the receiver stalled the core then holds its finished
// result until the output register is drained.
module distance_vector_route_update_unit #(
  parameter int NODES = dvr_pkg::NODES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // neighbor [3:0], destination [7:4], cost [27:8], zero [31:28]
  input  logic [dvr_pkg::IN_DATA_W-1:0]  in_tdata,
  // action [1:0]
  input  logic [dvr_pkg::ACT_W-1:0]      in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // best_cost [19:0], next_hop [23:20], entry_cost [43:24], improved [44],
  // stable [45], zero [47:46]
  output logic [dvr_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_wr_en,
  input  logic [dvr_pkg::ID_W-1:0]       cfg_wr_data
);
  import dvr_pkg::*;

  dvr_cmd_t ctrl_cmd;
  dvr_sts_t dp_sts;

  dvr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .sts        (dp_sts),
    .cmd        (ctrl_cmd)
  );

  dvr_dpath #(
    .NODES (NODES)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (ctrl_cmd),
    .sts         (dp_sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  // Reset leaves no result pending and no item taken during the sweep
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && !in_tready))
    else $error("result or ready straight after reset");

  // One item at a time: no second item in the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("item accepted while another is in work");

  // A result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.load_out |-> (!out_tvalid || out_tready))
    else $error("pending result overwritten");

endmodule
